[design/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Configuration register map (word index = paddr[2])
  localparam int  CFG_ADDR_W        = 3;
  localparam int  CFG_DATA_W        = 32;
  localparam int  WINDOW_SIZE_W     = 7;
  localparam logic REG_WINDOW_SIZE  = 1'b0;
  localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 7'd3;

  // Per-cell flags handed to the neighbor cells
  typedef struct packed {
    logic valid;   // cell holds a window entry
    logic ge_r;    // value >= removed sample (only while deleting)
    logic gt_s;    // value >  incoming sample (invalid reads as +inf)
  } cell_link_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic load;    // sample accepted this cycle
    logic del_en;  // window full: oldest sample leaves
    logic clear;   // empty the window
  } cell_ctl_t;

endpackage

[design/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted chain: removes / inserts by comparing with the
// incoming and removed samples and shifting from a neighbor.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int W        = 32,
  parameter bit IS_FIRST = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic signed [W-1:0] sample,
  input  logic signed [W-1:0] removed,
  input  cell_link_t          left_link,
  input  logic signed [W-1:0] left_value,
  input  cell_link_t          right_link,
  input  logic signed [W-1:0] right_value,
  output cell_link_t          link,
  output logic signed [W-1:0] value
);

  logic signed [W-1:0] value_r, value_nxt;
  logic                valid_r, valid_nxt;
  logic                gt_s, ge_r, take_right, take_left, after_del, keep;

  always_comb begin
    gt_s       = !valid_r || (value_r > sample);
    ge_r       = ctl.del_en && (!valid_r || (value_r >= removed));
    take_right = ge_r && !right_link.gt_s;
    take_left  = !IS_FIRST && !left_link.ge_r && left_link.gt_s;
    after_del  = !IS_FIRST && left_link.ge_r;
    // not the deleted slot, and shift state on both sides agrees
    keep       = (!ge_r || after_del) && (after_del == gt_s);

    priority if (take_right) begin
      value_nxt = right_value;
    end else if (take_left) begin
      value_nxt = left_value;
    end else if (keep) begin
      value_nxt = value_r;
    end else begin
      value_nxt = sample;
    end

    priority if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.load && !ctl.del_en) begin
      valid_nxt = valid_r || left_link.valid || IS_FIRST;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value_r <= value_nxt;
    end
  end

  assign link  = '{valid: valid_r, ge_r: ge_r, gt_s: gt_s};
  assign value = value_r;

endmodule

[design/swm_ring.sv]
// ----------------------------------------------------------------------------
// swm_ring
// Arrival-order sample ring: one write port, one registered read port with
// write-to-read bypass for the same address.
// ----------------------------------------------------------------------------
module swm_ring #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_q_r;
  logic [W-1:0] byp_data_r;
  logic         byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

[design/sliding_window_median_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running median filter: a sorted chain of cells plus an arrival-order ring.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle; the cell chain updates in a single step.
// Path: the chain updates at the edge that takes a sample, then the middle
//   cell picks are registered, then the doubling add into the output register.
// Output stall freezes the whole pipe, cells included, and stalls the input.
// Reset: window empty, window_size = 3; no clearing pass, cell valid bits
//   clear at once. A window_size write empties the window the same way.
// ----------------------------------------------------------------------------
module sliding_window_median_top
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  // median output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_WIDTH:0] out_median_times_two,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_ADDR_W-1:0]       paddr,
  input  logic [CFG_DATA_W-1:0]       pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int KW = $clog2(MAX_WINDOW + 1);                  // holds 0..MAX
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1; // slot index

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [WINDOW_SIZE_W-1:0] window_size_r;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE)
                ? {{(CFG_DATA_W-WINDOW_SIZE_W){1'b0}}, window_size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
    end else if (cfg_wr) begin
      window_size_r <= pwdata[WINDOW_SIZE_W-1:0];
    end
  end

  // effective window: zero reads as one, large values saturate
  logic [KW-1:0] eff_k;
  logic [KW-1:0] half_k;
  logic [PW-1:0] lo_idx, hi_idx;

  always_comb begin
    priority if (window_size_r == '0) begin
      eff_k = KW'(1);
    end else if (32'(window_size_r) > MAX_WINDOW) begin
      eff_k = KW'(MAX_WINDOW);
    end else begin
      eff_k = KW'(window_size_r);
    end
    half_k = eff_k >> 1;
    hi_idx = PW'(half_k);
    // odd window: both picks are the middle cell
    lo_idx = eff_k[0] ? PW'(half_k) : PW'(half_k - KW'(1));
  end

  // --------------------------------------------------------------------------
  // Handshake and fill control
  // --------------------------------------------------------------------------
  logic          advance, accept, full, emit;
  logic [KW-1:0] held_r, held_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [KW-1:0] pos_inc;
  logic          s1_valid_r, s2_valid_r, out_valid_r;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign full     = (held_r >= eff_k);
  assign emit     = full || ((held_r + KW'(1)) == eff_k);

  always_comb begin
    pos_inc  = KW'(pos_r) + KW'(1);
    pos_nxt  = (pos_inc >= eff_k) ? '0 : PW'(pos_inc);
    held_nxt = full ? held_r : held_r + KW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pos_r  <= '0;
    end else if (cfg_wr) begin
      held_r <= '0;
      pos_r  <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Arrival ring: removed sample for the next request is prefetched
  // --------------------------------------------------------------------------
  logic [W-1:0] ring_rd;

  swm_ring #(.W(W), .DEPTH(MAX_WINDOW), .AW(PW)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_addr (pos_r),
    .wr_data (in_sample),
    .rd_addr (accept ? pos_nxt : pos_r),
    .rd_data (ring_rd)
  );

  // --------------------------------------------------------------------------
  // Sorted cell chain, ascending from cell 0
  // --------------------------------------------------------------------------
  cell_ctl_t           ctl;
  cell_link_t          cell_link  [MAX_WINDOW];
  logic signed [W-1:0] cell_value [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] cell_valid;

  assign ctl = '{load: accept, del_en: full, clear: cfg_wr};

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_link_t          l_link, r_link;
    logic signed [W-1:0] l_value, r_value;

    if (i == 0) begin : g_left_edge
      assign l_link  = '{valid: 1'b1, ge_r: 1'b0, gt_s: 1'b0};
      assign l_value = '0;
    end else begin : g_left
      assign l_link  = cell_link[i-1];
      assign l_value = cell_value[i-1];
    end

    // beyond the last cell reads as +inf
    if (i == MAX_WINDOW - 1) begin : g_right_edge
      assign r_link  = '{valid: 1'b0, ge_r: 1'b1, gt_s: 1'b1};
      assign r_value = '0;
    end else begin : g_right
      assign r_link  = cell_link[i+1];
      assign r_value = cell_value[i+1];
    end

    swm_cell #(.W(W), .IS_FIRST(i == 0)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .sample      (in_sample),
      .removed     (ring_rd),
      .left_link   (l_link),
      .left_value  (l_value),
      .right_link  (r_link),
      .right_value (r_value),
      .link        (cell_link[i]),
      .value       (cell_value[i])
    );

    assign cell_valid[i] = cell_link[i].valid;
  end

  // --------------------------------------------------------------------------
  // Median pick and doubling add
  // --------------------------------------------------------------------------
  logic signed [W-1:0] lo_pick, hi_pick;
  logic signed [W-1:0] lo_r, hi_r;
  logic signed [W:0]   out_median_r;

  always_comb begin
    lo_pick = '0;
    hi_pick = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_pick = lo_pick | ((PW'(i) == lo_idx) ? cell_value[i] : '0);
      hi_pick = hi_pick | ((PW'(i) == hi_idx) ? cell_value[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= accept && emit;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lo_r         <= lo_pick;
      hi_r         <= hi_pick;
      out_median_r <= {lo_r[W-1], lo_r} + {hi_r[W-1], hi_r};
    end
  end

  assign out_valid            = out_valid_r;
  assign out_median_times_two = out_median_r;

`ifndef SYNTHESIS
  // occupied cells track the fill count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == held_r)
    else $error("cell valid count differs from fill count");

  // a result is only produced from a full window
  a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (held_r == eff_k))
    else $error("result issued from a partial window");

  // ring slot stays inside the window
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (KW'(pos_r) < eff_k))
    else $error("ring position beyond window");

  // a register write empties the window
  a_cfg_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (held_r == '0) && (pos_r == '0) && (cell_valid == '0))
    else $error("window not emptied by register write");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window median filter. A queue-fed
// driver offers samples, a cycle-accurate window tracker predicts each median
// at the accepted request, and the monitor checks every result in order.
// Runs go through several window sizes, including zero and saturating ones,
// with random sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import swm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW        = 64;
  localparam int SW          = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int SETTLE      = 16;    // settle time once the queues are empty

  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic signed [SW-1:0]    in_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SW:0]      out_median_times_two;
  logic                    psel      = 1'b0;
  logic                    penable   = 1'b0;
  logic                    pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr     = '0;
  logic [CFG_DATA_W-1:0]   pwdata    = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  sliding_window_median_top #(
    .MAX_WINDOW   (MAXW),
    .SAMPLE_WIDTH (SW)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_median_times_two (out_median_times_two),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] pending_samples[$];    // samples waiting for the driver
  logic signed [SW:0]   median_expect_q[$];    // predicted medians, oldest first
  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct     = 0;
  int                   hold_req_count = 0;    // bumped to ask for a long hold-off
  int                   error_count   = 0;
  int                   cycle_count   = 0;

  // Window tracker: own copy of ring, sorted store and window register
  logic [WINDOW_SIZE_W-1:0] window_reg = WINDOW_SIZE_RESET;
  logic signed [SW-1:0]     win_ring   [MAXW];
  logic signed [SW-1:0]     win_sorted [MAXW];
  logic                     ring_filled[MAXW] = '{default: 1'b0};
  int                       ring_ptr   = 0;
  int                       held_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Append a sample to the driver's queue
  task automatic add_pending(input logic signed [SW-1:0] s);
    pending_samples = {pending_samples, s};
  endtask

  // Append a predicted median to the monitor's queue
  task automatic add_expected(input logic signed [SW:0] m);
    median_expect_q = {median_expect_q, m};
  endtask

  // A window_size write empties the window, like reset
  task automatic empty_window();
    for (int i = 0; i < MAXW; i++) ring_filled[i] = 1'b0;
    ring_ptr   = 0;
    held_count = 0;
  endtask

  // Update the window with one accepted sample; queue a median once full
  task automatic track_window(input logic signed [SW-1:0] s);
    int                 k;
    int                 pos;
    int                 i;
    bit                 found;
    logic signed [SW:0] lo;
    logic signed [SW:0] hi;
    k = (window_reg == 0) ? 1 : (window_reg > MAXW) ? MAXW : int'(window_reg);
    pos = (ring_ptr >= k) ? 0 : ring_ptr;
    // full window: oldest sample leaves, any one copy of its value
    if (held_count >= k && ring_filled[pos]) begin
      found = 1'b0;
      for (i = 0; i < held_count; i++) begin
        if (!found && win_sorted[i] == win_ring[pos]) found = 1'b1;
        if (found && i + 1 < held_count) win_sorted[i] = win_sorted[i+1];
      end
      if (found) held_count--;
    end
    win_ring[pos]    = s;
    ring_filled[pos] = 1'b1;
    if (held_count < MAXW) begin
      i = held_count;
      while (i > 0 && win_sorted[i-1] > s) begin
        win_sorted[i] = win_sorted[i-1];
        i--;
      end
      win_sorted[i] = s;
      held_count++;
    end
    ring_ptr = (pos + 1 >= k) ? 0 : pos + 1;
    if (held_count >= k) begin
      if (k % 2 == 1) begin
        lo = win_sorted[k/2];
        hi = lo;
      end else begin
        lo = win_sorted[k/2-1];
        hi = win_sorted[k/2];
      end
      add_expected(lo + hi);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: holds a request until accepted, idles at random between requests
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction happens on the accepted request, from pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) track_window(in_sample);
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req_count) begin
      hold_seen <= hold_req_count;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: each accepted result against the oldest predicted median
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (median_expect_q.size() == 0) begin
        report_mismatch($sformatf("median %0d with no request pending",
                                  out_median_times_two));
      end else if (out_median_times_two !== median_expect_q[0]) begin
        report_mismatch($sformatf("median_times_two got %0d expected %0d",
                                  out_median_times_two, median_expect_q[0]));
        void'(median_expect_q.pop_front());
      end else begin
        void'(median_expect_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Wait until every request is taken and every median has come out, then
  // let the pipe empty of samples that only filled the window.
  task automatic drain_and_settle();
    while (pending_samples.size() > 0 || in_valid || median_expect_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write of window_size, then a read-back of the same register
  task automatic write_window(input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_SIZE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register takes the value at this edge
    window_reg = value[WINDOW_SIZE_W-1:0];
    empty_window();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[WINDOW_SIZE_W-1:0] !== window_reg)
      report_mismatch($sformatf("window_size read %0d expected %0d",
                                prdata[WINDOW_SIZE_W-1:0], window_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct <= 0;
        stall_pct     <= 0;
      end
      1: begin
        send_idle_pct <= 49;
        stall_pct     <= 0;
      end
      2: begin
        send_idle_pct <= 0;
        stall_pct     <= 49;
      end
      default: begin
        send_idle_pct <= 35;
        stall_pct     <= 35;
      end
    endcase
  endtask

  // Mix of full-range values, clustered small values (many duplicates)
  // and values at or near the extremes
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return $urandom_range(8) - 4;
      8: begin
        case ($urandom_range(3))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:       return $urandom_range(3) ? S_MAX - $urandom_range(3)
                                              : S_MIN + $urandom_range(3);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int sizes[16];
    int eff;
    int count;
    sizes = '{1, 2, 3, 4, 5, 7, 8, 16, 64, 127, 0, 33, 64, 6, 100, 2};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset window of 3, extremes on both ends, equal samples
    set_idling(0);
    pending_samples = '{S_MAX, S_MIN, S_MAX, 0, -1, S_MIN, S_MIN, 5, 5, 5};
    drain_and_settle();

    // Rewriting the same size must empty the window: two samples, then
    // three more, and only the last of them gives a median
    write_window(3);
    pending_samples = '{7, -7};
    drain_and_settle();
    write_window(3);
    pending_samples = '{1, 2, 3};
    drain_and_settle();

    // Zero window behaves as a window of one
    write_window(0);
    pending_samples = '{S_MAX, S_MIN, 9};
    drain_and_settle();

    // Even window: sums of the two middles at both extremes
    write_window(2);
    pending_samples = '{S_MIN, S_MIN, S_MAX, S_MAX, -1, 0};
    drain_and_settle();

    // Random phases over many window sizes and idling patterns
    for (int p = 0; p < 16; p++) begin
      write_window(sizes[p]);
      set_idling(p);
      eff   = (sizes[p] == 0) ? 1 : (sizes[p] > MAXW) ? MAXW : sizes[p];
      count = eff + 70 + $urandom_range(30);
      if (p == 8) begin
        // receiver holds off while samples keep coming: input backs up
        hold_req_count <= hold_req_count + 1;
      end
      if (p == 5) begin
        // sender pauses mid-phase until all medians are out
        for (int i = 0; i < count / 2; i++) add_pending(pick_sample());
        while (pending_samples.size() > 0 || in_valid || median_expect_q.size() > 0)
          @(posedge clk);
        for (int i = count / 2; i < count; i++) add_pending(pick_sample());
      end else begin
        for (int i = 0; i < count; i++) add_pending(pick_sample());
      end
      drain_and_settle();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
